// ===== design/mcpe_pkg.sv =====
`timescale 1ns / 1ps

package mcpe_pkg;

	localparam int ACTION_BITS    = 2;
	localparam int HOLD_BITS      = 11;
	localparam int LIMIT_BITS     = 10;
	localparam int ALPHA_BITS     = 17;
	localparam int CASH_BITS      = 48;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET        = 10'd5;
	localparam logic [ALPHA_BITS-1:0] ALPHA_SHORT_RESET  = 17'd10082;
	localparam logic [ALPHA_BITS-1:0] ALPHA_LONG_RESET   = 17'd4855;
	localparam logic [ALPHA_BITS-1:0] ALPHA_SIGNAL_RESET = 17'd13107;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_HOLD = 2'd0,
		ACT_BUY  = 2'd1,
		ACT_SELL = 2'd2
	} action_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_MAX_POSITION = 2'd0,
		CFG_ALPHA_SHORT  = 2'd1,
		CFG_ALPHA_LONG   = 2'd2,
		CFG_ALPHA_SIGNAL = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		SEL_SHORT  = 2'd0,
		SEL_LONG   = 2'd1,
		SEL_SIGNAL = 2'd2
	} ema_sel_t;

	typedef struct packed {
		logic     load;
		logic     seed;
		logic     diff;
		logic     mul_lo;
		logic     mul_hi;
		logic     acc;
		logic     upd;
		logic     macd;
		logic     decide;
		logic     pmul;
		logic     out_load;
		ema_sel_t sel;
	} mcpe_cmd_t;

	typedef struct packed {
		logic seen_first;
	} mcpe_status_t;

endpackage

// ===== design/mcpe_ctrl.sv =====
`timescale 1ns / 1ps

module mcpe_ctrl
	import mcpe_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  mcpe_status_t status,
	output mcpe_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_DIFF,
		ST_MLO,
		ST_MHI,
		ST_ACC,
		ST_UPD,
		ST_MACD,
		ST_DECIDE,
		ST_PMUL,
		ST_PNL
	} state_t;

	state_t   state_q;
	ema_sel_t sel_q;
	logic     out_valid_q;
	logic     out_free;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.sel      = sel_q;
		cmd.load     = (state_q == ST_IDLE) && s_axis_tvalid;
		cmd.seed     = (state_q == ST_SEED);
		cmd.diff     = (state_q == ST_DIFF);
		cmd.mul_lo   = (state_q == ST_MLO);
		cmd.mul_hi   = (state_q == ST_MHI);
		cmd.acc      = (state_q == ST_ACC);
		cmd.upd      = (state_q == ST_UPD);
		cmd.macd     = (state_q == ST_MACD);
		cmd.decide   = (state_q == ST_DECIDE);
		cmd.pmul     = (state_q == ST_PMUL);
		cmd.out_load = (state_q == ST_PNL) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= SEL_SHORT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						sel_q   <= SEL_SHORT;
						state_q <= status.seen_first ? ST_DIFF : ST_SEED;
					end
				end
				ST_SEED: state_q <= ST_DECIDE;
				ST_DIFF: state_q <= ST_MLO;
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_ACC;
				ST_ACC:  state_q <= ST_UPD;
				ST_UPD: begin
					case (sel_q)
						SEL_SHORT: begin
							sel_q   <= SEL_LONG;
							state_q <= ST_DIFF;
						end
						SEL_LONG: state_q <= ST_MACD;
						default:  state_q <= ST_DECIDE;
					endcase
				end
				ST_MACD: begin
					sel_q   <= SEL_SIGNAL;
					state_q <= ST_DIFF;
				end
				ST_DECIDE: state_q <= ST_PMUL;
				ST_PMUL:   state_q <= ST_PNL;
				ST_PNL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/mcpe_datapath.sv =====
`timescale 1ns / 1ps

module mcpe_datapath
	import mcpe_pkg::*;
#(
	parameter int PRICE_BITS    = 24,
	parameter int FRACTION_BITS = 16,
	parameter int IN_BITS       = ((PRICE_BITS + 7) / 8) * 8,
	parameter int OUT_BITS      = ((ACTION_BITS + HOLD_BITS + 2 * CASH_BITS
		+ 2 * (PRICE_BITS + FRACTION_BITS + 1) + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [IN_BITS-1:0]        s_axis_tdata,
	output logic [OUT_BITS-1:0]       m_axis_tdata,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ALPHA_BITS-1:0]     cfg_data,
	input  mcpe_cmd_t                 cmd,
	output mcpe_status_t              status
);

	localparam int EW = PRICE_BITS + FRACTION_BITS;   // price average width
	localparam int MW = EW + 1;                       // macd / signal width
	localparam int DW = EW + 2;                       // difference width
	localparam int LW = DW / 2;
	localparam int HW = DW - LW;
	localparam int AW = (FRACTION_BITS + 1 > ALPHA_BITS) ? FRACTION_BITS + 1 : ALPHA_BITS;
	localparam int PW = AW + DW;
	localparam int MPW = AW + HW + 2;
	localparam int QW = HOLD_BITS + PRICE_BITS + 1;
	localparam logic [AW-1:0] ALPHA_ONE = AW'(64'd1 << FRACTION_BITS);
	localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (FRACTION_BITS - 1));

	logic [LIMIT_BITS-1:0] limit_q;
	logic [ALPHA_BITS-1:0] alpha_short_q;
	logic [ALPHA_BITS-1:0] alpha_long_q;
	logic [ALPHA_BITS-1:0] alpha_signal_q;

	logic [PRICE_BITS-1:0]       price_q;
	logic [EW-1:0]               short_q;
	logic [EW-1:0]               long_q;
	logic signed [MW-1:0]        signal_q;
	logic signed [MW-1:0]        macd_q;
	logic                        seen_q;
	logic signed [HOLD_BITS-1:0] hold_q;
	logic signed [CASH_BITS-1:0] cash_q;
	action_t                     action_q;
	logic signed [DW-1:0]        d_q;
	logic signed [MPW-1:0]       prod_q;
	logic signed [PW-1:0]        acc_q;
	logic signed [QW-1:0]        pprod_q;
	logic [OUT_BITS-1:0]         out_data_q;

	logic [ALPHA_BITS-1:0]       alpha_raw;
	logic [AW-1:0]               alpha_ext;
	logic [AW-1:0]               alpha_c;
	logic signed [DW-1:0]        x_sel;
	logic signed [DW-1:0]        ema_sel;
	logic signed [DW-1:0]        rnd;
	logic signed [DW-1:0]        ema_new;
	logic signed [AW:0]          mul_a;
	logic signed [HW:0]          mul_b;
	logic signed [HOLD_BITS:0]   hold_e;
	logic signed [HOLD_BITS:0]   limit_s;
	logic                        go_up;
	logic                        go_down;
	logic signed [CASH_BITS:0]   cash_e;
	logic signed [CASH_BITS:0]   price_e;
	logic signed [CASH_BITS:0]   pnl_sum;
	logic signed [CASH_BITS-1:0] pnl_sat;

	function automatic logic signed [CASH_BITS-1:0] sat_cash(input logic signed [CASH_BITS:0] v);
		if (v[CASH_BITS] != v[CASH_BITS-1]) begin
			return v[CASH_BITS] ? {1'b1, {(CASH_BITS-1){1'b0}}} : {1'b0, {(CASH_BITS-1){1'b1}}};
		end
		return v[CASH_BITS-1:0];
	endfunction

	// operand selection for the shared ema step
	always_comb begin
		case (cmd.sel)
			SEL_SHORT: begin
				alpha_raw = alpha_short_q;
				ema_sel   = $signed({2'b00, short_q});
				x_sel     = $signed({2'b00, price_q, {FRACTION_BITS{1'b0}}});
			end
			SEL_LONG: begin
				alpha_raw = alpha_long_q;
				ema_sel   = $signed({2'b00, long_q});
				x_sel     = $signed({2'b00, price_q, {FRACTION_BITS{1'b0}}});
			end
			default: begin
				alpha_raw = alpha_signal_q;
				ema_sel   = $signed({signal_q[MW-1], signal_q});
				x_sel     = $signed({macd_q[MW-1], macd_q});
			end
		endcase
	end

	// weights above one act as exactly one
	assign alpha_ext = AW'(alpha_raw);
	assign alpha_c   = (alpha_ext > ALPHA_ONE) ? ALPHA_ONE : alpha_ext;
	assign mul_a     = $signed({1'b0, alpha_c});
	assign mul_b     = cmd.mul_lo ? $signed({{(HW + 1 - LW){1'b0}}, d_q[LW-1:0]})
	                              : $signed({d_q[DW-1], d_q[DW-1:LW]});

	assign rnd     = acc_q[FRACTION_BITS+DW-1:FRACTION_BITS];
	assign ema_new = ema_sel + rnd;

	assign hold_e  = {hold_q[HOLD_BITS-1], hold_q};
	assign limit_s = $signed({2'b00, limit_q});
	assign go_up   = (macd_q > signal_q) && (hold_e < limit_s);
	assign go_down = !go_up && (macd_q < signal_q) && (hold_e > -limit_s);
	assign cash_e  = {cash_q[CASH_BITS-1], cash_q};
	assign price_e = $signed({{(CASH_BITS + 1 - PRICE_BITS){1'b0}}, price_q});
	assign pnl_sum = cash_e + (CASH_BITS + 1)'(pprod_q);
	assign pnl_sat = sat_cash(pnl_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q        <= LIMIT_RESET;
			alpha_short_q  <= ALPHA_SHORT_RESET;
			alpha_long_q   <= ALPHA_LONG_RESET;
			alpha_signal_q <= ALPHA_SIGNAL_RESET;
			seen_q         <= 1'b0;
			short_q        <= '0;
			long_q         <= '0;
			signal_q       <= '0;
			hold_q         <= '0;
			cash_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_MAX_POSITION: limit_q        <= cfg_data[LIMIT_BITS-1:0];
					CFG_ALPHA_SHORT:  alpha_short_q  <= cfg_data;
					CFG_ALPHA_LONG:   alpha_long_q   <= cfg_data;
					CFG_ALPHA_SIGNAL: alpha_signal_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.seed) begin
				seen_q   <= 1'b1;
				short_q  <= {price_q, {FRACTION_BITS{1'b0}}};
				long_q   <= {price_q, {FRACTION_BITS{1'b0}}};
				signal_q <= '0;
			end
			if (cmd.upd) begin
				case (cmd.sel)
					SEL_SHORT: short_q  <= ema_new[EW-1:0];
					SEL_LONG:  long_q   <= ema_new[EW-1:0];
					default:   signal_q <= ema_new[MW-1:0];
				endcase
			end
			if (cmd.decide) begin
				if (go_up) begin
					hold_q <= hold_q + HOLD_BITS'(1);
					cash_q <= sat_cash(cash_e - price_e);
				end else if (go_down) begin
					hold_q <= hold_q - HOLD_BITS'(1);
					cash_q <= sat_cash(cash_e + price_e);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			price_q <= s_axis_tdata[PRICE_BITS-1:0];
		end
		if (cmd.seed) begin
			macd_q <= '0;
		end
		if (cmd.macd) begin
			macd_q <= $signed({1'b0, short_q}) - $signed({1'b0, long_q});
		end
		if (cmd.diff) begin
			d_q <= x_sel - ema_sel;
		end
		// low half product first, then high half into the same register
		if (cmd.mul_lo || cmd.mul_hi) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.mul_hi) begin
			acc_q <= PW'(prod_q) + HALF;
		end
		if (cmd.acc) begin
			acc_q <= acc_q + (PW'(prod_q) <<< LW);
		end
		if (cmd.decide) begin
			action_q <= go_up ? ACT_BUY : (go_down ? ACT_SELL : ACT_HOLD);
		end
		if (cmd.pmul) begin
			pprod_q <= hold_q * $signed({1'b0, price_q});
		end
		if (cmd.out_load) begin
			out_data_q <= OUT_BITS'({signal_q, macd_q, pnl_sat, cash_q, hold_q, action_q});
		end
	end

	assign m_axis_tdata      = out_data_q;
	assign status.seen_first = seen_q;

endmodule

// ===== design/macd_crossover_position_engine_core.sv =====
`timescale 1ns / 1ps
// one item at a time: a new item is accepted only once the result of the previous one
// is in the output register; one shared multiplier runs two partial products per ema,
// three emas in turn (the first item seeds them), then come the position and p&l steps
// a pending result sits in the output register while the next item is accepted
// reset: arst_n low clears averages, position, cash and handshakes, restores registers

module macd_crossover_position_engine_core
	import mcpe_pkg::*;
#(
	parameter int PRICE_BITS    = 24,
	parameter int FRACTION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// price
	input  logic [((PRICE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// action, holding, cash, marked_pnl, macd_value, signal_value
	output logic [((ACTION_BITS + HOLD_BITS + 2 * CASH_BITS
		+ 2 * (PRICE_BITS + FRACTION_BITS + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ALPHA_BITS-1:0]     cfg_data
);

	mcpe_cmd_t    cmd;
	mcpe_status_t status;

	mcpe_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	mcpe_datapath #(
		.PRICE_BITS    (PRICE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

// ===== design/mcpe_checker.sv =====
`timescale 1ns / 1ps

module mcpe_checker #(
	parameter int PRICE_BITS    = 24,
	parameter int FRACTION_BITS = 16,
	parameter int OUT_BITS      = ((2 + 11 + 96 + 2 * (PRICE_BITS + FRACTION_BITS + 1) + 7) / 8) * 8
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [OUT_BITS-1:0] m_axis_tdata
);

	// a stalled result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted while busy");

	// action code is hold, buy or sell
	a_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'b11)
		else $error("illegal action code");

	// reset clears the result side
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

endmodule

bind macd_crossover_position_engine_core mcpe_checker #(
	.PRICE_BITS    (PRICE_BITS),
	.FRACTION_BITS (FRACTION_BITS)
) u_mcpe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import mcpe_pkg::*;

	localparam int PRICE_BITS    = 24;
	localparam int FRAC_BITS     = 16;
	localparam int PRICE_MAX     = (1 << PRICE_BITS) - 1;
	localparam longint ALPHA_ONE = 64'd1 << FRAC_BITS;
	localparam longint CASH_TOP  = (64'sd1 <<< (CASH_BITS - 1)) - 1;
	localparam longint CASH_BOT  = -CASH_TOP - 1;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int ITEM_TARGET   = 1800;

	// one result, laid out as on m_axis_tdata (action in the lowest bits)
	typedef struct packed {
		logic signed [40:0] signal_value;
		logic signed [40:0] macd_value;
		logic signed [47:0] marked_pnl;
		logic signed [47:0] cash;
		logic signed [10:0] holding;
		action_t            action;
	} trade_result_t;

	localparam int RESULT_BITS = $bits(trade_result_t);

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [PRICE_BITS-1:0]   s_axis_tdata;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [191:0]            m_axis_tdata;
	logic                    cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [ALPHA_BITS-1:0]   cfg_data;

	macd_crossover_position_engine_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// predictor state and register copies
	logic [LIMIT_BITS-1:0] max_pos;
	logic [ALPHA_BITS-1:0] alpha_short, alpha_long, alpha_signal;
	longint short_avg, long_avg, signal_avg, shares, cash_bal;
	bit     seeded;

	trade_result_t pending_trades[$];
	bit  quiet;
	int  errors, n_sent, n_checked, n_buys, n_sells, n_writes, peak_pos;
	int  cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_trades.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= quiet || ($urandom_range(99) >= 27);
	end

	function automatic longint clamp48(longint v);
		if (v > CASH_TOP)
			return CASH_TOP;
		if (v < CASH_BOT)
			return CASH_BOT;
		return v;
	endfunction

	// avg + round(alpha * (target - avg)), alpha above one taken as one
	function automatic longint ema_step(longint avg, longint target, logic [ALPHA_BITS-1:0] alpha);
		longint a, d, q, r;
		a = (alpha > ALPHA_ONE) ? ALPHA_ONE : longint'(alpha);
		d = target - avg;
		q = d >>> FRAC_BITS;
		r = d & (ALPHA_ONE - 1);
		return avg + a * q + ((a * r + (ALPHA_ONE >> 1)) >>> FRAC_BITS);
	endfunction

	function automatic trade_result_t trade_step(logic [PRICE_BITS-1:0] price);
		trade_result_t res;
		longint p, px, macd, lim, pnl;
		p   = longint'(price);
		px  = p <<< FRAC_BITS;
		lim = longint'(max_pos);
		if (!seeded) begin
			short_avg  = px;
			long_avg   = px;
			signal_avg = 0;
			seeded     = 1'b1;
			macd       = 0;
		end else begin
			short_avg  = ema_step(short_avg, px, alpha_short);
			long_avg   = ema_step(long_avg, px, alpha_long);
			macd       = short_avg - long_avg;
			signal_avg = ema_step(signal_avg, macd, alpha_signal);
		end
		res.action = ACT_HOLD;
		if (macd > signal_avg && shares < lim) begin
			res.action = ACT_BUY;
			shares++;
			cash_bal = clamp48(cash_bal - p);
		end else if (macd < signal_avg && shares > -lim) begin
			res.action = ACT_SELL;
			shares--;
			cash_bal = clamp48(cash_bal + p);
		end
		pnl = clamp48(cash_bal + shares * p);
		if (shares > peak_pos)
			peak_pos = int'(shares);
		if (-shares > peak_pos)
			peak_pos = int'(-shares);
		res.holding      = shares[10:0];
		res.cash         = cash_bal[47:0];
		res.marked_pnl   = pnl[47:0];
		res.macd_value   = macd[40:0];
		res.signal_value = signal_avg[40:0];
		return res;
	endfunction

	function automatic void check_field(string name, logic signed [63:0] want,
		logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		trade_result_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_trades.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				want = pending_trades.pop_front();
				got  = trade_result_t'(m_axis_tdata[RESULT_BITS-1:0]);
				n_checked++;
				check_field("action", want.action, got.action);
				check_field("holding", want.holding, got.holding);
				check_field("cash", want.cash, got.cash);
				check_field("marked_pnl", want.marked_pnl, got.marked_pnl);
				check_field("macd_value", want.macd_value, got.macd_value);
				check_field("signal_value", want.signal_value, got.signal_value);
			end
		end
	end

	// called right after a falling edge, returns right after one
	task automatic send_price(input logic [PRICE_BITS-1:0] price);
		trade_result_t want;
		want = trade_step(price);
		pending_trades = {pending_trades, want};
		n_sent++;
		if (want.action == ACT_BUY)
			n_buys++;
		if (want.action == ACT_SELL)
			n_sells++;
		while (!quiet && $urandom_range(99) < 27) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = price;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (pending_trades.size() != 0)
			@(negedge clk);
	endtask

	// only while the block is idle
	task automatic write_reg(input cfg_index_t idx, input logic [ALPHA_BITS-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		n_writes++;
		case (idx)
			CFG_MAX_POSITION: begin
				max_pos = value[LIMIT_BITS-1:0];
			end
			CFG_ALPHA_SHORT: begin
				alpha_short = value;
			end
			CFG_ALPHA_LONG: begin
				alpha_long = value;
			end
			default: begin
				alpha_signal = value;
			end
		endcase
	endtask

	// trending random walk with runs of random length, some items pure noise
	task automatic send_walk(input int count, input int base, input int step,
		input int noise_pct);
		int px, dir, left;
		px   = base;
		dir  = 1;
		left = 0;
		repeat (count) begin
			if (left == 0) begin
				dir  = $urandom_range(1) ? 1 : -1;
				left = $urandom_range(40, 6);
			end
			left--;
			px = px + dir * int'($urandom_range(step)) + int'($urandom_range(step / 4)) - step / 8;
			if (px < 0)
				px = 0;
			if (px > PRICE_MAX)
				px = PRICE_MAX;
			if ($urandom_range(99) < noise_pct)
				send_price(PRICE_BITS'($urandom_range(PRICE_MAX)));
			else
				send_price(PRICE_BITS'(px));
		end
	endtask

	task automatic test_directed();
		send_price(24'h400000);
		send_price(24'hFFFFFF);
		send_price(24'h000000);
		send_price(24'hFFFFFF);
		send_price(24'h000000);
		for (int i = 1; i <= 9; i++)
			send_price(PRICE_BITS'(24'h200000 + i * 24'h040000));
		for (int i = 1; i <= 9; i++)
			send_price(PRICE_BITS'(24'h600000 - i * 24'h050000));
		wait_drained();
	endtask

	// lower the limit under the current position, position may only shrink
	task automatic test_limit_shrink();
		send_walk(50, 24'h100000, 24'h008000, 0);
		wait_drained();
		write_reg(CFG_MAX_POSITION, 17'h1FC02);
		send_walk(40, 24'h100000, 24'h008000, 0);
		wait_drained();
		write_reg(CFG_MAX_POSITION, 17'h00000);
		send_walk(30, 24'h100000, 24'h008000, 0);
		wait_drained();
	endtask

	task automatic test_alpha_corners();
		write_reg(CFG_MAX_POSITION, 17'd20);
		write_reg(CFG_ALPHA_SHORT, 17'h10000);
		write_reg(CFG_ALPHA_LONG, 17'h00000);
		write_reg(CFG_ALPHA_SIGNAL, 17'h1FFFF);
		send_walk(60, 24'h800000, 24'h020000, 0);
		wait_drained();
		write_reg(CFG_ALPHA_SHORT, 17'h00000);
		write_reg(CFG_ALPHA_LONG, 17'h1FFFF);
		write_reg(CFG_ALPHA_SIGNAL, 17'h10001);
		send_walk(60, 24'h800000, 24'h020000, 0);
		wait_drained();
	endtask

	// no idling on either side here
	task automatic test_wide_limit();
		write_reg(CFG_MAX_POSITION, 17'h1FFFF);
		write_reg(CFG_ALPHA_SHORT, ALPHA_SHORT_RESET);
		write_reg(CFG_ALPHA_LONG, 17'd0);
		write_reg(CFG_ALPHA_SIGNAL, 17'd40000);
		quiet = 1'b1;
		send_walk(250, 24'h400000, 24'h004000, 0);
		wait_drained();
		quiet = 1'b0;
	endtask

	task automatic test_random_phases();
		logic [ALPHA_BITS-1:0] a;
		while (n_sent < ITEM_TARGET) begin
			case ($urandom_range(3))
				0: write_reg(CFG_MAX_POSITION, 17'd0);
				1: write_reg(CFG_MAX_POSITION, 17'd1);
				2: write_reg(CFG_MAX_POSITION, ALPHA_BITS'($urandom_range(20, 2)));
				default: write_reg(CFG_MAX_POSITION, ALPHA_BITS'($urandom_range(1023)));
			endcase
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(9))
					0: a = 17'd0;
					1: a = 17'h10000;
					2: a = ALPHA_BITS'($urandom_range(131071, 65537));
					default: a = ALPHA_BITS'($urandom_range(65536, 1));
				endcase
				write_reg(cfg_index_t'(k + 1), a);
			end
			send_walk($urandom_range(160, 60), $urandom_range(PRICE_MAX),
				$urandom_range(24'h040000, 16), $urandom_range(1) ? 0 : 10);
			wait_drained();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_MAX_POSITION;
		cfg_data      = '0;
		quiet         = 1'b0;
		errors        = 0;
		n_sent        = 0;
		n_checked     = 0;
		n_buys        = 0;
		n_sells       = 0;
		n_writes      = 0;
		peak_pos      = 0;
		max_pos       = LIMIT_RESET;
		alpha_short   = ALPHA_SHORT_RESET;
		alpha_long    = ALPHA_LONG_RESET;
		alpha_signal  = ALPHA_SIGNAL_RESET;
		short_avg     = 0;
		long_avg      = 0;
		signal_avg    = 0;
		shares        = 0;
		cash_bal      = 0;
		seeded        = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_limit_shrink();
		test_alpha_corners();
		test_wide_limit();
		test_random_phases();

		wait_drained();
		repeat (25) @(negedge clk);
		$display("checked %0d prices (%0d buys, %0d sells, peak position %0d)",
			n_checked, n_buys, n_sells, peak_pos);
		$display("across %0d register writes incl. zero, one and clamped alphas",
			n_writes);
		if (errors == 0 && pending_trades.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/mcpe_pkg.sv
design/mcpe_ctrl.sv
design/mcpe_datapath.sv
design/macd_crossover_position_engine_core.sv
design/mcpe_checker.sv
tb/tb.sv
